/* sv/clamped_table_linear_interp_core_assert.svh */
// Assertion macros for the interpolation core.
`ifndef CLAMPED_TABLE_LINEAR_INTERP_CORE_ASSERT_SVH
`define CLAMPED_TABLE_LINEAR_INTERP_CORE_ASSERT_SVH
// Assert that a condition implies a consequence in the same cycle.
`define CTLI_ASSERT_IMPL(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define CTLI_ASSERT_NEXT(label, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("assertion failed");
`endif

/* sv/ctli_pkg.sv */
// ----------------------------------------------------------------------------
// ctli_pkg
// Shared types and constants for the interpolation core.
// ----------------------------------------------------------------------------
package ctli_pkg;
    localparam int TableDepth = 64;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = 7;
    localparam int ValW = 32;
    localparam int KindW = 3;
    localparam int QDepth = 2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [KindW-1:0] KIND_INTERP = 3'd0;
    localparam logic [KindW-1:0] KIND_EXACT = 3'd1;
    localparam logic [KindW-1:0] KIND_LOW = 3'd2;
    localparam logic [KindW-1:0] KIND_HIGH = 3'd3;
    localparam logic [KindW-1:0] KIND_ZERO = 3'd4;

    typedef struct packed {
        logic opcode;
        logic [IdxW-1:0] entry_index;
        logic signed [ValW-1:0] entry_breakpoint;
        logic signed [ValW-1:0] entry_value;
        logic signed [ValW-1:0] query_value;
    } item_t;
endpackage

/* sv/ctli_front.sv */
// ----------------------------------------------------------------------------
// ctli_front
// Two-entry command queue between input port and execution engine.
// ----------------------------------------------------------------------------
module ctli_front
    import ctli_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    output logic  full,
    input  item_t in_item,
    output logic  cmd_valid,
    input  logic  cmd_take,
    output item_t cmd_item
);
    item_t mem_reg [QDepth];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic do_push, do_pop;

    assign full = (cnt_reg == 2'(QDepth));
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd_item = mem_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop = cmd_take && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

/* sv/ctli_back.sv */
// ----------------------------------------------------------------------------
// ctli_back
// Table memory, breakpoint search and serial interpolation divider.
// ----------------------------------------------------------------------------
module ctli_back
    import ctli_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [CntW-1:0]         entry_count,
    input  logic                    cmd_valid,
    output logic                    cmd_take,
    input  item_t                   cmd_item,
    output logic                    res_valid,
    input  logic                    res_take,
    output logic signed [ValW-1:0]  res_value,
    output logic [KindW-1:0]        res_kind
);
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RD0   = 8'b0000_0010,
        ST_RDN   = 8'b0000_0100,
        ST_SCAN  = 8'b0000_1000,
        ST_PREV  = 8'b0001_0000,
        ST_MUL   = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    localparam int ProdW = 2 * ValW + 2;
    localparam int DenW = ValW + 1;

    logic signed [ValW-1:0] bp_mem [TableDepth];
    logic signed [ValW-1:0] val_mem [TableDepth];
    logic signed [ValW-1:0] rd_bp_reg, rd_val_reg;
    logic [IdxW-1:0] raddr;

    state_t state_reg;
    logic [IdxW-1:0] idx_reg;
    logic [IdxW-1:0] last_reg;
    logic signed [ValW-1:0] q_reg, b0_reg, bk_reg, vk_reg, v0_reg;
    logic [ProdW-1:0] rem_reg;
    logic [ProdW-1:0] quo_reg;
    logic [DenW-1:0] den_reg;
    logic [6:0] bit_reg;
    logic neg_reg;
    logic signed [ValW-1:0] out_val_reg;
    logic [KindW-1:0] out_kind_reg;

    logic [IdxW-1:0] last_idx;
    logic signed [ValW:0] d_w, dv_w, den_w;
    logic [DenW-1:0] md, mdv, mden;
    logic [ProdW-1:0] rem_sh, quo_cap;
    logic signed [ProdW+1:0] sum_w;

    always_comb
    begin
        if (entry_count == '0)
            last_idx = '0;
        else if (entry_count > CntW'(TableDepth))
            last_idx = IdxW'(TableDepth - 1);
        else
            last_idx = IdxW'(entry_count - 7'd1);
    end

    // Scan: fetch the next entry while the search goes on, else the lower
    // bracketing entry.
    always_comb
    begin
        case (state_reg)
            ST_IDLE: raddr = '0;
            ST_RD0:  raddr = last_reg;
            ST_SCAN: raddr = (q_reg < rd_bp_reg || idx_reg == last_reg)
                             ? idx_reg - IdxW'(1) : idx_reg + IdxW'(1);
            default: raddr = idx_reg;
        endcase
    end

    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid;

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd_item.opcode == OP_LOAD)
        begin
            bp_mem[cmd_item.entry_index] <= cmd_item.entry_breakpoint;
            val_mem[cmd_item.entry_index] <= cmd_item.entry_value;
        end
        rd_bp_reg <= bp_mem[raddr];
        rd_val_reg <= val_mem[raddr];
    end

    assign d_w = (ValW+1)'(q_reg) - (ValW+1)'(b0_reg);
    assign dv_w = (ValW+1)'(vk_reg) - (ValW+1)'(v0_reg);
    assign den_w = (ValW+1)'(bk_reg) - (ValW+1)'(b0_reg);
    assign md = d_w[ValW] ? DenW'(-d_w) : DenW'(d_w);
    assign mdv = dv_w[ValW] ? DenW'(-dv_w) : DenW'(dv_w);
    assign mden = den_w[ValW] ? DenW'(-den_w) : DenW'(den_w);
    assign rem_sh = {rem_reg[ProdW-2:0], quo_reg[ProdW-1]};
    assign quo_cap = (quo_reg > ProdW'(64'h4_0000_0000)) ? ProdW'(64'h4_0000_0000) : quo_reg;
    assign sum_w = neg_reg ? ((ProdW+2)'(v0_reg) - (ProdW+2)'(quo_cap))
                           : ((ProdW+2)'(v0_reg) + (ProdW+2)'(quo_cap));

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                q_reg <= cmd_item.query_value;
                last_reg <= last_idx;
                idx_reg <= IdxW'(1);
            end
            ST_RD0:
            begin
                b0_reg <= rd_bp_reg;
                v0_reg <= rd_val_reg;
            end
            ST_RDN:
            begin
                if (b0_reg == '0)
                begin
                    out_val_reg <= '0;
                    out_kind_reg <= KIND_ZERO;
                end
                else if (q_reg >= rd_bp_reg)
                begin
                    out_val_reg <= rd_val_reg;
                    out_kind_reg <= KIND_HIGH;
                end
                else
                begin
                    out_val_reg <= v0_reg;
                    out_kind_reg <= KIND_LOW;
                end
            end
            ST_SCAN:
            begin
                bk_reg <= rd_bp_reg;
                vk_reg <= rd_val_reg;
                if (q_reg == rd_bp_reg)
                begin
                    out_val_reg <= rd_val_reg;
                    out_kind_reg <= KIND_EXACT;
                end
                else
                begin
                    out_kind_reg <= KIND_INTERP;
                    if (!(q_reg < rd_bp_reg) && idx_reg != last_reg)
                    begin
                        idx_reg <= idx_reg + IdxW'(1);
                    end
                end
            end
            ST_PREV:
            begin
                b0_reg <= rd_bp_reg;
                v0_reg <= rd_val_reg;
            end
            ST_MUL:
            begin
                quo_reg <= ProdW'(md) * ProdW'(mdv);
                den_reg <= mden;
                rem_reg <= '0;
                bit_reg <= 7'(ProdW);
                neg_reg <= (d_w[ValW] != dv_w[ValW]) != den_w[ValW];
            end
            ST_DIV:
            begin
                if (den_reg == '0)
                begin
                    out_val_reg <= v0_reg;
                end
                else if (bit_reg != 7'd0)
                begin
                    bit_reg <= bit_reg - 7'd1;
                    if (rem_sh >= ProdW'(den_reg))
                    begin
                        rem_reg <= rem_sh - ProdW'(den_reg);
                        quo_reg <= {quo_reg[ProdW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[ProdW-2:0], 1'b0};
                    end
                end
                else if (sum_w > (ProdW+2)'(32'sh7FFF_FFFF))
                begin
                    out_val_reg <= 32'sh7FFF_FFFF;
                end
                else if (sum_w < -(ProdW+2)'(33'sh0_8000_0000))
                begin
                    out_val_reg <= 32'sh8000_0000;
                end
                else
                begin
                    out_val_reg <= ValW'(sum_w);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (cmd_take && cmd_item.opcode == OP_QUERY)
                        state_reg <= ST_RD0;
                ST_RD0:
                    state_reg <= ST_RDN;
                ST_RDN:
                    if (b0_reg == '0 || q_reg >= rd_bp_reg || q_reg <= b0_reg)
                        state_reg <= ST_OUT;
                    else
                        state_reg <= ST_SCAN;
                ST_SCAN:
                    if (q_reg == rd_bp_reg)
                        state_reg <= ST_OUT;
                    else if (q_reg < rd_bp_reg || idx_reg == last_reg)
                        state_reg <= ST_PREV;
                ST_PREV:
                    state_reg <= ST_MUL;
                ST_MUL:
                    state_reg <= ST_DIV;
                ST_DIV:
                    if (den_reg == '0 || bit_reg == 7'd0)
                        state_reg <= ST_OUT;
                ST_OUT:
                    if (res_take)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign res_valid = (state_reg == ST_OUT);
    assign res_value = out_val_reg;
    assign res_kind = out_kind_reg;
endmodule

/* sv/clamped_table_linear_interp_core.sv */
// Sequence: a zero-rule or clamped result follows its input transfer via
// the RD0 and RDN states; the search scans the entries in turn (up to 63),
// and an interpolation adds fetch, multiply, 66-step divide and saturate.
// Occupancy: one item at a time in the engine; a query holds it until its
// result is popped; a two-entry input queue hides loads. Reset: rst_n async
// active low; entry_count to 1, queues empty.
// ----------------------------------------------------------------------------
// clamped_table_linear_interp_core
// Top level: APB register, command queue and lookup/interpolation engine.
// ----------------------------------------------------------------------------
`include "clamped_table_linear_interp_core_assert.svh"
module clamped_table_linear_interp_core
    import ctli_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // APB-style configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [0:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    // Input queue side
    input  logic                   push,
    output logic                   full,
    input  logic                   opcode,
    input  logic [IdxW-1:0]        entry_index,
    input  logic signed [ValW-1:0] entry_breakpoint,
    input  logic signed [ValW-1:0] entry_value,
    input  logic signed [ValW-1:0] query_value,
    // Result queue side
    output logic                   empty,
    input  logic                   pop,
    output logic signed [ValW-1:0] result_value,
    output logic [KindW-1:0]       result_kind
);
    logic [CntW-1:0] entry_count_reg;
    item_t in_item, cmd_item;
    logic cmd_valid, cmd_take, res_valid;

    // Registers sit at word addresses; only entry_count (offset 0) exists.
    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? 32'(entry_count_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= CntW'(1);
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            // Take the low 7 bits of the transfer.
            entry_count_reg <= pwdata[CntW-1:0];
        end
    end

    assign in_item = '{opcode: opcode, entry_index: entry_index,
                       entry_breakpoint: entry_breakpoint,
                       entry_value: entry_value, query_value: query_value};

    // Front: accept and hold items until the engine is free.
    ctli_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_item   (in_item),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd_item  (cmd_item)
    );

    // Back: loads, search and interpolation; the result register is the
    // single-entry output queue.
    ctli_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count_reg),
        .cmd_valid   (cmd_valid),
        .cmd_take    (cmd_take),
        .cmd_item    (cmd_item),
        .res_valid   (res_valid),
        .res_take    (pop),
        .res_value   (result_value),
        .res_kind    (result_kind)
    );

    assign empty = !res_valid;

    // The engine never takes a command while a result is waiting.
    `CTLI_ASSERT_IMPL(a_no_take_while_result, !empty, !cmd_take)
    // A popped result clears the output the next cycle.
    `CTLI_ASSERT_NEXT(a_pop_clears, pop && !empty, empty)
    // Result kinds stay within the defined codes.
    `CTLI_ASSERT_IMPL(a_kind_range, !empty, result_kind <= KIND_ZERO)
endmodule
